// ===== hdl/vsmf_pkg.sv =====
// Shared types and constants for the velocity safety mode filter.
package vsmf_pkg;

    localparam int TIME_WIDTH = 32;

    localparam int SCALE_W = 16;
    localparam logic [SCALE_W-1:0] FULL_SCALE = 16'd32768;
    localparam logic [23:0] RELEASE_RATE_RST = 24'd8389;

    localparam int MQ_DEPTH = 4;
    localparam int MQ_CW = $clog2(MQ_DEPTH + 1);
    localparam int OQ_DEPTH = 2;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STOP_HOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_CLEAR_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOW_CLEAR_HOLD = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_RATE = 2'd3;

    typedef enum logic [1:0] {
        ACT_PASS   = 2'd0,
        ACT_SLOW   = 2'd1,
        ACT_STOP   = 2'd2,
        ACT_NODATA = 2'd3
    } act_t;

    // classified word handed from front to back
    typedef struct packed {
        act_t               act;
        logic               first;
        logic               backward;
        logic [SCALE_W-1:0] req;
        logic [SCALE_W-1:0] rise;
    } item_t;

    typedef struct packed {
        logic [15:0] min_stop_hold;
        logic [15:0] stop_release_hold;
        logic [15:0] slow_release_hold;
    } hold_cfg_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [SCALE_W-1:0] scale;
        logic               stop;
    } res_t;

endpackage

// ===== hdl/vsmf_fifo.sv =====
// Small register FIFO used between front and back and on the result side.
module vsmf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       rd_en,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (rd_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (wr_en && !rd_en)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd_en && !wr_en)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assign rdata = mem[rd_ptr_reg];
    assign count = count_reg;

endmodule

// ===== hdl/vsmf_front.sv =====
// Front: accepts words, clamps the scale, times the gap and computes the rise.
module vsmf_front #(
    parameter int TIME_WIDTH = vsmf_pkg::TIME_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  req_action,
    input  logic signed [16:0]          req_scale,
    input  logic [31:0]                 now_ms,
    input  logic [23:0]                 release_rate,
    input  logic [vsmf_pkg::MQ_CW-1:0]  q_count,
    output logic                        out_valid,
    output vsmf_pkg::item_t             out_item,
    output logic [TIME_WIDTH-1:0]       out_now
);

    localparam int TW = TIME_WIDTH;
    localparam int NW = (TW > 32) ? TW : 32;
    localparam int EW = (TW > 24) ? TW : 24;
    localparam int FW = vsmf_pkg::MQ_CW + 1;

    logic                accept;
    logic [NW-1:0]       now_ext;
    logic [TW-1:0]       now_t;
    logic                backward;
    logic [TW-1:0]       diff;
    logic [EW-1:0]       el_ext;
    logic [15:0]         req_clamped;
    logic [46:0]         prod;
    logic [38:0]         rise_sh;
    logic [15:0]         rise;

    logic                started_reg;
    logic [TW-1:0]       last_reg;

    logic                s1_valid_reg;
    vsmf_pkg::act_t      s1_act_reg;
    logic [15:0]         s1_req_reg;
    logic [TW-1:0]       s1_now_reg;
    logic                s1_first_reg;
    logic                s1_back_reg;
    logic                s1_sat_reg;
    logic [22:0]         s1_el_reg;

    logic                s2_valid_reg;
    vsmf_pkg::item_t     s2_item_reg;
    logic [TW-1:0]       s2_now_reg;

    // credit check: queue words plus words still in the two stages
    assign full = (FW'(q_count) + FW'(s1_valid_reg) + FW'(s2_valid_reg))
                  >= FW'(vsmf_pkg::MQ_DEPTH);
    assign accept = push && !full;

    assign now_ext = NW'(now_ms);
    assign now_t   = now_ext[TW-1:0];
    assign backward = started_reg && (now_t < last_reg);
    assign diff    = now_t - last_reg;
    assign el_ext  = (started_reg && !backward) ? EW'(diff) : '0;

    always_comb
    begin
        if (req_scale[16])
        begin
            req_clamped = '0;
        end
        else if (req_scale[15:0] > vsmf_pkg::FULL_SCALE)
        begin
            req_clamped = vsmf_pkg::FULL_SCALE;
        end
        else
        begin
            req_clamped = req_scale[15:0];
        end
    end

    // Q1.15 units times 256, so drop 8 fraction bits
    assign prod    = 47'(release_rate) * 47'(s1_el_reg);
    assign rise_sh = prod[46:8];

    always_comb
    begin
        if (s1_sat_reg && (release_rate != '0))
        begin
            rise = vsmf_pkg::FULL_SCALE;
        end
        else if (rise_sh > 39'(vsmf_pkg::FULL_SCALE))
        begin
            rise = vsmf_pkg::FULL_SCALE;
        end
        else
        begin
            rise = rise_sh[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg  <= 1'b0;
            last_reg     <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (accept)
            begin
                started_reg <= 1'b1;
                last_reg    <= now_t;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_act_reg   <= vsmf_pkg::act_t'(req_action);
            s1_req_reg   <= req_clamped;
            s1_now_reg   <= now_t;
            s1_first_reg <= !started_reg;
            s1_back_reg  <= backward;
            s1_sat_reg   <= |el_ext[EW-1:23];
            s1_el_reg    <= el_ext[22:0];
        end
        if (s1_valid_reg)
        begin
            s2_item_reg.act      <= s1_act_reg;
            s2_item_reg.first    <= s1_first_reg;
            s2_item_reg.backward <= s1_back_reg;
            s2_item_reg.req      <= s1_req_reg;
            s2_item_reg.rise     <= rise;
            s2_now_reg           <= s1_now_reg;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;
    assign out_now   = s2_now_reg;

endmodule

// ===== hdl/vsmf_back.sv =====
// Back: mode state machine, hold timers and applied scale, one word a cycle while out_room.
module vsmf_back #(
    parameter int TIME_WIDTH = vsmf_pkg::TIME_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  vsmf_pkg::item_t       in_item,
    input  logic [TIME_WIDTH-1:0] in_now,
    input  logic                  out_room,
    input  vsmf_pkg::hold_cfg_t   hold_cfg,
    output logic                  take,
    output vsmf_pkg::res_t        out_res
);

    localparam int TW = TIME_WIDTH;

    typedef enum logic [1:0] {
        MODE_PASS = 2'd0,
        MODE_SLOW = 2'd1,
        MODE_STOP = 2'd2
    } mode_t;

    mode_t               mode_reg, mode_next;
    logic [15:0]         scale_reg, scale_next;
    logic [TW-1:0]       stop_at_reg, stop_at_next;
    logic [TW-1:0]       clear_at_reg, clear_at_next;
    logic                clear_run_reg, clear_run_next;

    logic [15:0]         target;
    logic [16:0]         sum;
    logic [1:0]          shown;

    assign take = in_valid && out_room;

    always_comb
    begin
        mode_next      = mode_reg;
        scale_next     = scale_reg;
        stop_at_next   = stop_at_reg;
        clear_at_next  = clear_at_reg;
        clear_run_next = clear_run_reg;
        target         = '0;
        sum            = '0;

        if (in_item.first)
        begin
            mode_next      = MODE_PASS;
            scale_next     = vsmf_pkg::FULL_SCALE;
            stop_at_next   = in_now;
            clear_at_next  = in_now;
            clear_run_next = 1'b0;
        end
        if (in_item.backward)
        begin
            clear_run_next = 1'b0;
            if (mode_next == MODE_STOP)
            begin
                stop_at_next = in_now;
                scale_next   = '0;
            end
        end

        if (in_item.act == vsmf_pkg::ACT_STOP || in_item.act == vsmf_pkg::ACT_NODATA)
        begin
            if (mode_next != MODE_STOP)
            begin
                stop_at_next = in_now;
            end
            mode_next      = MODE_STOP;
            scale_next     = '0;
            clear_run_next = 1'b0;
        end
        else if (mode_next == MODE_STOP)
        begin
            if (in_item.act == vsmf_pkg::ACT_PASS)
            begin
                if ((in_now - stop_at_next) >= TW'(hold_cfg.min_stop_hold))
                begin
                    if (!clear_run_next)
                    begin
                        clear_at_next  = in_now;
                        clear_run_next = 1'b1;
                    end
                    if ((in_now - clear_at_next) >= TW'(hold_cfg.stop_release_hold))
                    begin
                        mode_next      = MODE_PASS;
                        clear_run_next = 1'b0;
                    end
                end
            end
            else
            begin
                clear_run_next = 1'b0;
            end
        end
        else if (in_item.act == vsmf_pkg::ACT_SLOW)
        begin
            mode_next      = MODE_SLOW;
            clear_run_next = 1'b0;
        end
        else if (mode_next == MODE_SLOW)
        begin
            if (!clear_run_next)
            begin
                clear_at_next  = in_now;
                clear_run_next = 1'b1;
            end
            if ((in_now - clear_at_next) >= TW'(hold_cfg.slow_release_hold))
            begin
                mode_next      = MODE_PASS;
                clear_run_next = 1'b0;
            end
        end
        else
        begin
            mode_next      = MODE_PASS;
            clear_run_next = 1'b0;
        end

        case (mode_next)
            MODE_STOP: target = '0;
            MODE_SLOW: target = (in_item.act == vsmf_pkg::ACT_SLOW) ? in_item.req : scale_next;
            default:   target = vsmf_pkg::FULL_SCALE;
        endcase

        // drop at once, rise by the precomputed step, saturate at target
        if (target <= scale_next)
        begin
            scale_next = target;
        end
        else
        begin
            sum = 17'(scale_next) + 17'(in_item.rise);
            if (sum >= 17'(target))
            begin
                scale_next = target;
            end
            else
            begin
                scale_next = sum[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_PASS;
            scale_reg     <= vsmf_pkg::FULL_SCALE;
            stop_at_reg   <= '0;
            clear_at_reg  <= '0;
            clear_run_reg <= 1'b0;
        end
        else if (take)
        begin
            mode_reg      <= mode_next;
            scale_reg     <= scale_next;
            stop_at_reg   <= stop_at_next;
            clear_at_reg  <= clear_at_next;
            clear_run_reg <= clear_run_next;
        end
    end

    // pass below full scale reads as slow
    always_comb
    begin
        shown = mode_next;
        if (mode_next == MODE_PASS && scale_next < vsmf_pkg::FULL_SCALE)
        begin
            shown = MODE_SLOW;
        end
    end

    assign out_res.action = shown;
    assign out_res.scale  = scale_next;
    assign out_res.stop   = (mode_next == MODE_STOP);

endmodule

// ===== hdl/velocity_safety_mode_filter_top.sv =====
// Top level: config registers, front, word queue, back and result queue.
// A result word passes the front stages, word queue and back into the result queue.
// Throughput: one word per cycle while the queues have room; front stages are gap
// timing and the rise multiply, the back updates mode, timers and scale together.
// Reset (rst_n low, async): mode pass, scale full, timers and queues cleared,
// release_rate 8389 and all hold times 0.
module velocity_safety_mode_filter_top #(
    parameter int TIME_WIDTH = vsmf_pkg::TIME_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        req_action,
    input  logic signed [16:0]                req_scale,
    input  logic [31:0]                       now_ms,
    output logic                              empty,
    input  logic                              pop,
    output logic [1:0]                        shown_action,
    output logic [15:0]                       applied_scale,
    output logic                              stop_active,
    input  logic                              cfg_wr_en,
    input  logic [vsmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [vsmf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int ITEM_W = $bits(vsmf_pkg::item_t);
    localparam int MQ_W   = ITEM_W + TIME_WIDTH;
    localparam int RES_W  = $bits(vsmf_pkg::res_t);
    localparam int OQ_CW  = $clog2(vsmf_pkg::OQ_DEPTH + 1);

    vsmf_pkg::hold_cfg_t           hold_cfg_reg;
    logic [23:0]                   release_rate_reg;

    logic                          f_valid;
    vsmf_pkg::item_t               f_item;
    logic [TIME_WIDTH-1:0]         f_now;
    logic [vsmf_pkg::MQ_CW-1:0]    mq_count;
    logic [MQ_W-1:0]               mq_rdata;
    vsmf_pkg::item_t               b_item;
    logic [TIME_WIDTH-1:0]         b_now;
    logic                          b_take;
    logic                          b_room;
    vsmf_pkg::res_t                b_res;
    logic [RES_W-1:0]              oq_rdata;
    vsmf_pkg::res_t                oq_res;
    logic [OQ_CW-1:0]              oq_count;
    logic                          oq_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cfg_reg     <= '0;
            release_rate_reg <= vsmf_pkg::RELEASE_RATE_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                vsmf_pkg::REG_MIN_STOP_HOLD:
                    hold_cfg_reg.min_stop_hold <= cfg_wdata[15:0];
                vsmf_pkg::REG_STOP_CLEAR_HOLD:
                    hold_cfg_reg.stop_release_hold <= cfg_wdata[15:0];
                vsmf_pkg::REG_SLOW_CLEAR_HOLD:
                    hold_cfg_reg.slow_release_hold <= cfg_wdata[15:0];
                vsmf_pkg::REG_RELEASE_RATE:
                    release_rate_reg <= cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    vsmf_front #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_action   (req_action),
        .req_scale    (req_scale),
        .now_ms       (now_ms),
        .release_rate (release_rate_reg),
        .q_count      (mq_count),
        .out_valid    (f_valid),
        .out_item     (f_item),
        .out_now      (f_now)
    );

    vsmf_fifo #(
        .WIDTH (MQ_W),
        .DEPTH (vsmf_pkg::MQ_DEPTH)
    ) u_mid_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (f_valid),
        .wdata ({f_item, f_now}),
        .rd_en (b_take),
        .rdata (mq_rdata),
        .count (mq_count)
    );

    assign b_item = vsmf_pkg::item_t'(mq_rdata[MQ_W-1:TIME_WIDTH]);
    assign b_now  = mq_rdata[TIME_WIDTH-1:0];

    assign oq_pop = pop && !empty;
    assign b_room = (oq_count != OQ_CW'(vsmf_pkg::OQ_DEPTH)) || oq_pop;

    vsmf_back #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (mq_count != '0),
        .in_item  (b_item),
        .in_now   (b_now),
        .out_room (b_room),
        .hold_cfg (hold_cfg_reg),
        .take     (b_take),
        .out_res  (b_res)
    );

    vsmf_fifo #(
        .WIDTH (RES_W),
        .DEPTH (vsmf_pkg::OQ_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .wr_en (b_take),
        .wdata (b_res),
        .rd_en (oq_pop),
        .rdata (oq_rdata),
        .count (oq_count)
    );

    assign oq_res         = vsmf_pkg::res_t'(oq_rdata);
    assign empty          = (oq_count == '0);
    assign shown_action   = oq_res.action;
    assign applied_scale  = oq_res.scale;
    assign stop_active    = oq_res.stop;

endmodule
